// File: sv/sdq_pkg.sv
package sdq_pkg;

  // Field widths of one transaction
  localparam int unsigned VID_W  = 14;
  localparam int unsigned RID_W  = 7;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STS_W  = 2;
  localparam int unsigned FILL_W = 5;

  // Packed stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 64;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EARLIEST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LATEST   = 2'd2;

  // Result status codes
  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

  // One stored entry
  typedef struct packed {
    logic [VID_W-1:0]  vehicle_id;
    logic [RID_W-1:0]  route_id;
    logic [TIME_W-1:0] depart_time;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;       // capture a result this cycle
    logic             insert;     // place the new entry in sorted position
    logic             pop_front;  // remove the earliest entry
    logic             pop_back;   // remove the latest entry
    logic [STS_W-1:0] status;     // status of the captured result
  } sdq_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } sdq_sts_t;

endpackage

// File: sv/sdq_ctrl.sv
module sdq_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [sdq_pkg::CMD_W-1:0] in_cmd,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  input  sdq_pkg::sdq_sts_t        dp_sts,
  output sdq_pkg::sdq_ctrl_t       dp_ctrl
);
  import sdq_pkg::*;

  localparam logic S_IDLE = 1'b0;  // no result held
  localparam logic S_HOLD = 1'b1;  // result waiting in output register

  logic state_r, state_nxt;
  logic accept;

  // Output register frees up in the same cycle it is taken
  assign in_tready  = (state_r == S_IDLE) || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_HOLD);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (accept)          state_nxt = S_HOLD;
        else if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Command decode against store status
  always_comb begin
    dp_ctrl        = '0;
    dp_ctrl.load   = accept;
    dp_ctrl.status = ST_OK;
    if (accept) begin
      unique case (in_cmd)
        CMD_INSERT: begin
          if (dp_sts.full) dp_ctrl.status = ST_FULL;
          else             dp_ctrl.insert = 1'b1;
        end
        CMD_EARLIEST: begin
          if (dp_sts.empty) dp_ctrl.status    = ST_EMPTY;
          else              dp_ctrl.pop_front = 1'b1;
        end
        CMD_LATEST: begin
          if (dp_sts.empty) dp_ctrl.status   = ST_EMPTY;
          else              dp_ctrl.pop_back = 1'b1;
        end
        default: dp_ctrl.status = ST_OK;  // unused code: no effect
      endcase
    end
  end

endmodule

// File: sv/sdq_dp.sv
module sdq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sdq_pkg::sdq_ctrl_t          dp_ctrl,
  output sdq_pkg::sdq_sts_t           dp_sts,
  input  sdq_pkg::entry_t             new_entry,
  output logic [sdq_pkg::STS_W-1:0]   res_status,
  output sdq_pkg::entry_t             res_entry,
  output logic [sdq_pkg::FILL_W-1:0]  res_fill
);
  import sdq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  entry_t           slot_r   [DEPTH];
  entry_t           slot_nxt [DEPTH];
  logic [CW-1:0]    count_r, count_nxt;
  logic [DEPTH-1:0] shift;
  logic [CW-1:0]    last_pos;
  logic [IW-1:0]    last_idx;
  entry_t           pick;
  logic [CW+FILL_W-1:0] fill_ext;

  logic [STS_W-1:0] res_status_r;
  entry_t           res_entry_r;
  logic [FILL_W-1:0] res_fill_r;

  assign dp_sts.full  = (count_r == CW'(DEPTH));
  assign dp_sts.empty = (count_r == '0);

  // Per-slot compare: a valid slot later than the new entry moves up one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      shift[i] = (CW'(i) < count_r) &&
                 (slot_r[i].depart_time > new_entry.depart_time);
    end
  end

  // Next contents of every slot
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_nxt[i] = slot_r[i];
      if (dp_ctrl.insert) begin
        if (i > 0 && shift[(i > 0) ? i - 1 : 0]) slot_nxt[i] = slot_r[(i > 0) ? i - 1 : 0];
        else if (shift[i] || CW'(i) == count_r)  slot_nxt[i] = new_entry;
      end else if (dp_ctrl.pop_front) begin
        if (i < DEPTH - 1) slot_nxt[i] = slot_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Fill count update
  always_comb begin
    count_nxt = count_r;
    if (dp_ctrl.insert)                          count_nxt = count_r + 1'b1;
    else if (dp_ctrl.pop_front || dp_ctrl.pop_back) count_nxt = count_r - 1'b1;
  end

  // Removed entry: head slot or last valid slot
  assign last_pos = count_r - 1'b1;
  assign last_idx = last_pos[IW-1:0];

  always_comb begin
    pick = '0;
    if (dp_ctrl.pop_front)     pick = slot_r[0];
    else if (dp_ctrl.pop_back) pick = slot_r[last_idx];
  end

  assign fill_ext = {{FILL_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) slot_r[i] <= slot_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (dp_ctrl.load) begin
      res_status_r <= dp_ctrl.status;
      res_entry_r  <= pick;
      res_fill_r   <= fill_ext[FILL_W-1:0];
    end
  end

  assign res_status = res_status_r;
  assign res_entry  = res_entry_r;
  assign res_fill   = res_fill_r;

endmodule

// File: sv/sorted_double_ended_departure_queue.sv
// Sorted double-ended departure queue.
// Holds up to DEPTH entries (vehicle id, route id, departure time) sorted by
// time; among equal times the older insert stays ahead.
// Input channel (in_*): one command per transaction. in_tuser carries the
// command (insert, release earliest, release latest); in_tdata carries the
// entry, used on insert only.
// Output channel (out_*): exactly one result per command: status in
// out_tuser, removed entry (zero unless a release succeeded) and the fill
// count after the command in out_tdata.
// Latency: the result is valid in the cycle after the command is accepted.
// Throughput: one command per cycle while results are taken; every slot compares
// against the new time in parallel, so the whole slot row shifts together.
// A stalled result stays in the output register; a new command is taken in
// the cycle the held result is taken, otherwise in_tready stays low.
// Reset empties the queue (fill count zero); stored entries are not cleared.
module sorted_double_ended_departure_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [13:0] vehicle_id, [20:14] route_id, [52:21] depart_time, [55:53] zero
  input  logic [sdq_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] cmd
  input  logic [sdq_pkg::CMD_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [13:0] out_vehicle_id, [20:14] out_route_id, [52:21] out_depart_time,
  // [57:53] fill_count, [63:58] zero
  output logic [sdq_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic [sdq_pkg::STS_W-1:0]         out_tuser
);
  import sdq_pkg::*;

  sdq_ctrl_t         dp_ctrl;
  sdq_sts_t          dp_sts;
  entry_t            new_entry;
  entry_t            res_entry;
  logic [FILL_W-1:0] res_fill;

  // Unpack the incoming entry
  assign new_entry.vehicle_id  = in_tdata[13:0];
  assign new_entry.route_id    = in_tdata[20:14];
  assign new_entry.depart_time = in_tdata[52:21];

  sdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_sts     (dp_sts),
    .dp_ctrl    (dp_ctrl)
  );

  sdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_ctrl    (dp_ctrl),
    .dp_sts     (dp_sts),
    .new_entry  (new_entry),
    .res_status (out_tuser),
    .res_entry  (res_entry),
    .res_fill   (res_fill)
  );

  // Pack the result
  assign out_tdata = {6'b0, res_fill, res_entry.depart_time,
                      res_entry.route_id, res_entry.vehicle_id};

  // A dropped insert returns no entry
  a_full_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[52:0] == '0)
    else $error("full status with nonzero entry");

  // A release on an empty queue reports zero fill
  a_empty_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[57:53] == '0)
    else $error("empty status with nonzero fill count");

  // An insert into a non-full queue succeeds with a result next cycle
  a_insert_ok: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_INSERT && !dp_sts.full
    |=> out_tvalid && out_tuser == ST_OK)
    else $error("insert into non-full queue not reported ok");

  // Full and empty never hold together
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_sts.full && dp_sts.empty))
    else $error("queue flagged full and empty");

endmodule

// File: tb/sv/departure_checker.sv
`timescale 1ns / 1ps

module departure_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [sdq_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [sdq_pkg::CMD_W-1:0]      in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [sdq_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [sdq_pkg::STS_W-1:0]      out_tuser,
  output int unsigned                    fail_count,
  output int unsigned                    pending
);
  import sdq_pkg::*;

  // Bit positions inside tdata, lowest field first
  localparam int unsigned RID_LSB  = VID_W;
  localparam int unsigned TIME_LSB = VID_W + RID_W;
  localparam int unsigned FILL_LSB = TIME_LSB + TIME_W;
  localparam int unsigned PAD_LSB  = FILL_LSB + FILL_W;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    entry_t            removed;
    logic [FILL_W-1:0] fill;
  } departure_result_t;

  // Predicted store contents, earliest departure at the front
  entry_t            roster[$];
  departure_result_t awaited_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Apply one command to the predicted store and return its result
  function automatic departure_result_t apply_command(logic [CMD_W-1:0] cmd, entry_t item);
    departure_result_t res;
    int unsigned       slot;
    res        = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (roster.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // new entry goes after every entry with the same or an earlier time
          slot = roster.size();
          while (slot > 0 && roster[slot-1].depart_time > item.depart_time) slot--;
          roster.insert(slot, item);
        end
      end
      CMD_EARLIEST, CMD_LATEST: begin
        if (roster.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (cmd == CMD_EARLIEST) begin
          res.removed = roster.pop_front();
        end else begin
          res.removed = roster.pop_back();
        end
      end
      default: ;  // unused code leaves the store alone
    endcase
    res.fill = FILL_W'(roster.size());
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) flag_mismatch(what, want, got);
  endtask

  // Compare results first: a result taken now belongs to an earlier command
  always @(posedge clk) begin : monitor
    departure_result_t want;
    entry_t            item;
    if (!rst_n) begin
      roster.delete();
      awaited_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("unexpected result transaction", '0, out_tdata);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_tuser));
          check_field("vehicle_id", 64'(want.removed.vehicle_id),
                      64'(out_tdata[VID_W-1:0]));
          check_field("route_id", 64'(want.removed.route_id),
                      64'(out_tdata[RID_LSB +: RID_W]));
          check_field("depart_time", 64'(want.removed.depart_time),
                      64'(out_tdata[TIME_LSB +: TIME_W]));
          check_field("fill_count", 64'(want.fill), 64'(out_tdata[FILL_LSB +: FILL_W]));
          check_field("tdata padding", '0, 64'(out_tdata[OUT_DATA_W-1:PAD_LSB]));
        end
      end
      if (in_tvalid && in_tready) begin
        item.vehicle_id  = in_tdata[VID_W-1:0];
        item.route_id    = in_tdata[RID_LSB +: RID_W];
        item.depart_time = in_tdata[TIME_LSB +: TIME_W];
        awaited_results.push_back(apply_command(in_tuser, item));
      end
    end
    pending = awaited_results.size();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sdq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned PHASES       = 4;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // Command code the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STS_W-1:0]      out_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;
  bit          hold_request;

  sorted_double_ended_departure_queue #(
    .DEPTH (DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  departure_checker #(
    .DEPTH (DEPTH)
  ) u_departure_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin : receiver
    int unsigned hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic entry_t make_entry(logic [VID_W-1:0] vid, logic [RID_W-1:0] rid,
                                        logic [TIME_W-1:0] dep);
    entry_t e;
    e.vehicle_id  = vid;
    e.route_id    = rid;
    e.depart_time = dep;
    return e;
  endfunction

  // Mostly a narrow range so equal times are common, with extremes mixed in
  function automatic logic [TIME_W-1:0] random_depart_time();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      4:       return 32'hFFFF_FFF0 + $urandom_range(15);
      default: return $urandom_range(15);
    endcase
  endfunction

  // One command transaction, after an optional idle gap
  task automatic send_command(logic [CMD_W-1:0] cmd, entry_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W-VID_W-RID_W-TIME_W){1'b0}},
                  item.depart_time, item.route_id, item.vehicle_id};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  // Bursts that lean toward filling, draining or neither
  task automatic run_random(int unsigned item_total);
    int unsigned      sent;
    int unsigned      burst_left;
    int unsigned      insert_pct;
    logic [CMD_W-1:0] cmd;
    entry_t           item;
    sent       = 0;
    burst_left = 0;
    insert_pct = 50;
    while (sent < item_total) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(32, 8);
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      burst_left--;
      if ($urandom_range(99) < 4) begin
        cmd = CMD_UNUSED;
      end else if ($urandom_range(99) < insert_pct) begin
        cmd = CMD_INSERT;
      end else if ($urandom_range(1) == 1) begin
        cmd = CMD_EARLIEST;
      end else begin
        cmd = CMD_LATEST;
      end
      item = make_entry(VID_W'($urandom), RID_W'($urandom), random_depart_time());
      send_command(cmd, item);
      if (cmd != CMD_UNUSED) sent++;
    end
  endtask

  initial begin
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = CMD_INSERT;
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, field extremes, equal times, both release ends
    send_command(CMD_EARLIEST, make_entry('1, '1, '1));
    send_command(CMD_LATEST, make_entry('1, '1, '1));
    send_command(CMD_UNUSED, make_entry('1, '1, '1));
    send_command(CMD_INSERT, make_entry('0, '0, '0));
    send_command(CMD_INSERT, make_entry('1, '1, '1));
    send_command(CMD_INSERT, make_entry(14'd1234, 7'd5, 32'd100));
    send_command(CMD_INSERT, make_entry(14'd1235, 7'd6, 32'd100));
    send_command(CMD_INSERT, make_entry(14'd9999, 7'd99, 32'd100));
    send_command(CMD_UNUSED, make_entry(14'h2AAA, 7'h55, 32'hAAAA_AAAA));
    send_command(CMD_EARLIEST, make_entry('0, '0, '0));
    send_command(CMD_EARLIEST, make_entry('0, '0, '0));
    send_command(CMD_LATEST, make_entry('0, '0, '0));
    send_command(CMD_LATEST, make_entry('0, '0, '0));
    send_command(CMD_EARLIEST, make_entry('0, '0, '0));
    send_command(CMD_EARLIEST, make_entry('0, '0, '0));
    settle();

    // Random phases with different idling; the first one opens with a long hold-off
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_request   = 1'b1;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      run_random(RANDOM_ITEMS / PHASES);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
